>>> hdl/srdt_pkg.sv
// shared constants, codes and types of the scan result dedup table
package srdt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_READOUT = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_IMPROVED  = 3'd1;
  localparam logic [2:0] ST_UNCHANGED = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_ENTRY     = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [47:0]        dev_addr;
    logic signed [7:0]  strength;
    logic [15:0]        label_ref;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [47:0]        out_addr;
    logic signed [7:0]  out_strength;
    logic [15:0]        out_label_ref;
    logic [6:0]         occupancy;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic [47:0]        addr;
    logic signed [7:0]  strength;
    logic [15:0]        label;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS_SCAN,
    S_RD_SCAN,
    S_EMIT
  } state_t;

endpackage

>>> hdl/srdt_req_if.sv
// command channel of the scan result dedup table
interface srdt_req_if;
  logic             valid;
  logic             ready;
  srdt_pkg::req_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/srdt_rsp_if.sv
// result channel of the scan result dedup table
interface srdt_rsp_if;
  logic             valid;
  logic             ready;
  srdt_pkg::rsp_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/scan_result_dedup_table.sv
// scan result dedup table: device table in one memory with a sequential scanner
//
// req carries one command item (insert, sorted readout, clear); rsp carries
// result items, each with status, entry fields, occupancy and last.
// Only one command is worked on at a time; req.ready is high while idle.
// The table lives in a single-port-read memory with a registered read port,
// so insert and readout walk the n stored entries one read per cycle.
// Insert: when no address matches, the scan reads all n entries, compares the
// last one, closes the scan and registers the result; a match ends the scan
// early. Clear and readout of an empty table go straight to their result.
// Readout: one pass over the table per result, picking the strongest entry
// not yet sent (ties in insertion order).
// A result sits in the rsp output register until taken; while rsp is stalled
// the next result is still worked out, then held until the register is free,
// and a new command is taken once the last result is registered.
// Reset clears the entry count, so the table is empty; memory contents are
// left as they are and never read before being written.
module scan_result_dedup_table (
  input  logic        clk,
  input  logic        rst,
  srdt_req_if.sink    req,
  srdt_rsp_if.source  rsp
);

  srdt_pkg::state_t state, state_next;

  srdt_pkg::entry_t mem [srdt_pkg::TABLE_DEPTH];
  srdt_pkg::entry_t mem_q;
  logic                           mem_we;
  logic [srdt_pkg::IDX_W-1:0]     mem_wa;
  srdt_pkg::entry_t               mem_wd;

  srdt_pkg::req_t                 req_q;
  logic [srdt_pkg::CNT_W-1:0]     count;
  logic [srdt_pkg::CNT_W-1:0]     rd_ptr;
  logic [srdt_pkg::CNT_W-1:0]     k;
  logic                           pend_valid;
  logic [srdt_pkg::IDX_W-1:0]     pend_idx;

  logic                           first;
  logic signed [7:0]              last_str;
  logic [srdt_pkg::IDX_W-1:0]     last_idx;
  logic                           best_valid;
  srdt_pkg::entry_t               best;
  logic [srdt_pkg::IDX_W-1:0]     best_idx;

  logic [2:0]                     res_status;
  srdt_pkg::entry_t               res;
  logic                           res_last;

  logic                           accept;
  logic                           out_free;
  logic                           scanning;
  logic                           issue;
  logic                           pass_done;
  logic                           full;
  logic                           hit;
  logic                           improve;
  srdt_pkg::entry_t               upd;
  srdt_pkg::entry_t               new_entry;
  logic                           eligible;
  logic                           better;

  assign req.ready = (state == srdt_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign scanning  = (state == srdt_pkg::S_INS_SCAN) || (state == srdt_pkg::S_RD_SCAN);
  assign issue     = scanning && (rd_ptr != count);
  assign pass_done = !pend_valid && (rd_ptr == count);
  assign full      = (count == srdt_pkg::CNT_W'(srdt_pkg::TABLE_DEPTH));

  // insert compare on the entry that just came out of memory
  assign hit     = pend_valid && (mem_q.addr == req_q.dev_addr);
  assign improve = req_q.strength > mem_q.strength;

  always_comb begin
    upd = mem_q;
    if (improve) begin
      upd.strength = req_q.strength;
      if (req_q.label_ref != 16'd0 && mem_q.label == 16'd0) begin
        upd.label = req_q.label_ref;
      end
    end
  end

  assign new_entry.addr     = req_q.dev_addr;
  assign new_entry.strength = req_q.strength;
  assign new_entry.label    = req_q.label_ref;

  // readout: next entry after the last one sent, strongest first, lowest index on ties
  assign eligible = first || (mem_q.strength < last_str) ||
                    ((mem_q.strength == last_str) && (pend_idx > last_idx));
  assign better   = !best_valid || (mem_q.strength > best.strength);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (issue) begin
      mem_q <= mem[rd_ptr[srdt_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srdt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_wa     = pend_idx;
    mem_wd     = upd;
    unique case (state)
      srdt_pkg::S_IDLE: begin
        if (accept) begin
          unique case (req.payload.cmd)
            srdt_pkg::CMD_INSERT:  state_next = srdt_pkg::S_INS_SCAN;
            srdt_pkg::CMD_READOUT: begin
              state_next = (count == '0) ? srdt_pkg::S_EMIT : srdt_pkg::S_RD_SCAN;
            end
            srdt_pkg::CMD_CLEAR:   state_next = srdt_pkg::S_EMIT;
            default:               state_next = srdt_pkg::S_IDLE;
          endcase
        end
      end
      srdt_pkg::S_INS_SCAN: begin
        if (hit) begin
          state_next = srdt_pkg::S_EMIT;
          mem_we     = improve;
        end else if (pass_done) begin
          state_next = srdt_pkg::S_EMIT;
          if (!full) begin
            mem_we = 1'b1;
            mem_wa = count[srdt_pkg::IDX_W-1:0];
            mem_wd = new_entry;
          end
        end
      end
      srdt_pkg::S_RD_SCAN: begin
        if (pass_done) begin
          state_next = srdt_pkg::S_EMIT;
        end
      end
      srdt_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = res_last ? srdt_pkg::S_IDLE : srdt_pkg::S_RD_SCAN;
        end
      end
      default: state_next = srdt_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend_valid <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      if (accept && req.payload.cmd == srdt_pkg::CMD_CLEAR) begin
        count <= '0;
      end
      if (state == srdt_pkg::S_INS_SCAN && !hit && pass_done && !full) begin
        count <= count + 1'b1;
      end
      pend_valid <= issue;
      if (state == srdt_pkg::S_EMIT && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_ptr   <= rd_ptr + 1'b1;
      pend_idx <= rd_ptr[srdt_pkg::IDX_W-1:0];
    end
    if (accept) begin
      req_q      <= req.payload;
      rd_ptr     <= '0;
      best_valid <= 1'b0;
      first      <= 1'b1;
      k          <= '0;
      res        <= '0;
      res_last   <= 1'b1;
      res_status <= (req.payload.cmd == srdt_pkg::CMD_CLEAR) ? srdt_pkg::ST_CLEARED
                                                             : srdt_pkg::ST_EMPTY;
    end
    if (state == srdt_pkg::S_INS_SCAN) begin
      if (hit) begin
        res        <= upd;
        res_status <= improve ? srdt_pkg::ST_IMPROVED : srdt_pkg::ST_UNCHANGED;
      end else if (pass_done) begin
        res        <= new_entry;
        res_status <= full ? srdt_pkg::ST_FULL : srdt_pkg::ST_ADDED;
      end
    end
    if (state == srdt_pkg::S_RD_SCAN) begin
      if (pend_valid && eligible && better) begin
        best       <= mem_q;
        best_idx   <= pend_idx;
        best_valid <= 1'b1;
      end
      if (pass_done) begin
        res        <= best;
        res_status <= srdt_pkg::ST_ENTRY;
        res_last   <= (k + 1'b1) == count;
        last_str   <= best.strength;
        last_idx   <= best_idx;
        first      <= 1'b0;
        k          <= k + 1'b1;
      end
    end
    if (state == srdt_pkg::S_EMIT && out_free) begin
      rsp.payload.status        <= res_status;
      rsp.payload.out_addr      <= res.addr;
      rsp.payload.out_strength  <= res.strength;
      rsp.payload.out_label_ref <= res.label;
      rsp.payload.occupancy     <= 7'(count);
      rsp.payload.last          <= res_last;
      rd_ptr                    <= '0;
      best_valid                <= 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= srdt_pkg::CNT_W'(srdt_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_write_in_insert: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == srdt_pkg::S_INS_SCAN))
    else $error("table written outside insert");

  a_pend_in_range: assert property (@(posedge clk) disable iff (rst)
    (scanning && pend_valid) |-> (srdt_pkg::CNT_W'(pend_idx) < count))
    else $error("scan read beyond stored entries");

  a_entry_nonempty: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.status == srdt_pkg::ST_ENTRY) |->
      (rsp.payload.occupancy != 7'd0))
    else $error("entry item from an empty table");

endmodule
